// ===== hw/rtl/grc_pkg.sv =====
// Package for the grid ray cast column block: item structs, sequencer states,
// register indexes and reset values. No dependencies.
`default_nettype none

package grc_pkg;

    typedef struct packed {
        logic               req_type;
        logic [3:0]         row_index;
        logic [15:0]        row_bits;
        logic [23:0]        pos_x;
        logic [23:0]        pos_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
    } req_t;

    typedef struct packed {
        logic [11:0] column;
        logic [23:0] distance;
        logic        drawn;
        logic [11:0] start_row;
        logic [11:0] end_row;
        logic [7:0]  shade;
    } rsp_t;

    typedef enum logic [4:0] {
        S_IDLE, S_AXIS, S_FIRST, S_STEP, S_MULOC, S_DIVOC, S_WOC, S_SQA, S_SQC,
        S_SQRT0, S_WSQ, S_WQ, S_MAP, S_ADV, S_FIN, S_FLEN, S_WLEN, S_FSH, S_FSHD,
        S_WSH, S_OUT
    } state_t;

    localparam logic [2:0] REG_CELL_SIZE     = 3'd0;
    localparam logic [2:0] REG_MAX_DISTANCE  = 3'd1;
    localparam logic [2:0] REG_PERSP_SCALE   = 3'd2;
    localparam logic [2:0] REG_WALL_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd4;
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd5;

    localparam logic [15:0] RST_CELL_SIZE     = 16'd1000;
    localparam logic [15:0] RST_MAX_DISTANCE  = 16'd10000;
    localparam logic [15:0] RST_PERSP_SCALE   = 16'd1;
    localparam logic [11:0] RST_WALL_HEIGHT   = 12'd648;
    localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd1080;
    localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd1920;

    localparam int STORED_ROWS = 16;
    localparam int STORED_COLS = 16;

    localparam int DIV_W  = 41;   // widest dividend: |offset| * |direction|
    localparam int SQ_W   = 52;   // radicand width, even
    localparam int ROOT_W = SQ_W / 2;

endpackage

`default_nettype wire

// ===== hw/rtl/grid_ray_cast_column.sv =====
// Grid ray cast column: wall bitmap, axis walks and slice computation.
// Depends on grc_pkg for item structs, states and register constants.
//
// Usage: req carries one item per handshake (req_valid high, req_stall low).
// A row write item (req_type 0) stores row_bits in the wall map and gives no
// result. A ray item (req_type 1) walks the vertical grid
// lines, then the horizontal ones, and gives one rsp item with the nearest
// wall distance and the wall slice for the current screen column.
// A ray skips an axis with no motion along it; a walked axis finds its first
// line, then for each grid step that tests a cell does two restoring divides,
// one square root, three multiplies, a map read and sequencing; a step that
// ends the walk early does less. Slice length and shade are computed only
// when the slice is drawn.
// All of this runs on one shared divider, one shared root unit and one 25x25
// multiplier under the sequencer, so req_stall stays high until the result
// is loaded into the output register.
// A result waits in the output register while rsp_stall is high; the block
// goes back to idle and takes the next item; a new ray result waits in S_OUT,
// with req_stall high, while the register is still full.
// Reset clears the sequencer, output valid, column counter and registers to
// their reset values; the wall map holds nothing until rows are written.
// cfg_write writes register cfg_index with cfg_data; write only while idle.
`default_nettype none

module grid_ray_cast_column
    import grc_pkg::*;
#(
    parameter int MAP_WIDTH  = 16,
    parameter int MAP_HEIGHT = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire req_t        req_item,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output rsp_t             rsp_item,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // Map limits as seen by the wall test: cells beyond the stored map are open
    localparam int MW_LIM = (MAP_WIDTH  < STORED_COLS) ? MAP_WIDTH  : STORED_COLS;
    localparam int MH_LIM = (MAP_HEIGHT < STORED_ROWS) ? MAP_HEIGHT : STORED_ROWS;

    // Configuration
    logic [15:0] cell_size_reg, max_distance_reg, persp_scale_reg;
    logic [11:0] wall_height_reg, screen_height_reg, screen_width_reg;

    // Wall map, no reset
    logic [15:0] wall_map [STORED_ROWS];
    logic [15:0] map_word_reg;

    // Sequencer and walk state
    state_t             state_reg, state_next;
    logic               axis_reg, axis_next;
    logic [23:0]        px_reg, py_reg, px_next, py_next;
    logic signed [15:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [23:0]        c_reg, d_reg, c_next, d_next;
    logic signed [26:0] line_reg, line_next, idx_reg, idx_next;
    logic [25:0]        travel_reg, travel_next;
    logic signed [26:0] oa_reg, oa_next, q_reg, q_next;
    logic [23:0]        aoc_reg, aoc_next, dist_reg, dist_next, z_reg, z_next;
    logic [49:0]        sqa_reg, sqa_next, prod_reg;
    logic               drawn_reg, drawn_next;
    logic [11:0]        start_reg, start_next, end_reg, end_next;
    logic [7:0]         shade_reg, shade_next;
    logic [11:0]        col_reg, col_next;
    rsp_t               rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    // Shared multiplier
    logic [24:0] mul_a, mul_b;

    // Shared divider
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [23:0]        div_divisor;
    logic               div_busy_reg;
    logic [5:0]         div_cnt_reg;
    logic [23:0]        div_rem_reg, div_den_reg;
    logic [DIV_W-1:0]   div_quo_reg;
    logic [24:0]        div_partial;
    logic [25:0]        div_diff;

    // Shared square root
    logic               sq_start;
    logic [SQ_W-1:0]    sq_radicand;
    logic               sq_busy_reg;
    logic [4:0]         sq_cnt_reg;
    logic [SQ_W-1:0]    sq_rad_reg;
    logic [28:0]        sq_rem_reg, sq_rem_shift, sq_trial;
    logic [ROOT_W-1:0]  sq_root_reg;

    // Axis view: along / across components of the current walk
    logic [23:0]        pa, pc;
    logic signed [15:0] da, dc;
    logic [15:0]        da_mag, dc_mag;
    logic               da_pos;
    logic [24:0]        oa_mag;
    logic signed [26:0] ia;
    logic               ia_ok, ic_ok, wall_hit;
    logic [3:0]         map_row, map_col;
    logic signed [26:0] map_a_lim;
    logic [DIV_W-1:0]   map_c_lim, ic_lim;
    logic [11:0]        len;
    logic               accept;
    logic [12:0]        col_inc;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

    assign pa     = axis_reg ? py_reg : px_reg;
    assign pc     = axis_reg ? px_reg : py_reg;
    assign da     = axis_reg ? dy_reg : dx_reg;
    assign dc     = axis_reg ? dx_reg : dy_reg;
    assign da_pos = !da[15];
    assign da_mag = da[15] ? 16'(-da) : 16'(da);
    assign dc_mag = dc[15] ? 16'(-dc) : 16'(dc);
    assign oa_mag = oa_reg[26] ? 25'(-oa_reg) : 25'(oa_reg);

    assign map_a_lim = axis_reg ? 27'(MAP_HEIGHT) : 27'(MAP_WIDTH);
    assign map_c_lim = axis_reg ? DIV_W'(MAP_WIDTH) : DIV_W'(MAP_HEIGHT);

    // Cell behind the line on the walk axis; cell of the crossing point across
    assign ia      = idx_reg - (da_pos ? 27'sd0 : 27'sd1);
    assign ia_ok   = (ia >= 27'sd0) && (ia < (axis_reg ? 27'(MH_LIM) : 27'(MW_LIM)));
    assign ic_lim  = axis_reg ? DIV_W'(MW_LIM) : DIV_W'(MH_LIM);
    assign ic_ok   = div_quo_reg < ic_lim;
    assign map_row = axis_reg ? ia[3:0] : div_quo_reg[3:0];
    assign map_col = axis_reg ? div_quo_reg[3:0] : ia[3:0];
    assign wall_hit = ia_ok && ic_ok && map_word_reg[map_col];

    assign len = (div_quo_reg > DIV_W'(screen_height_reg)) ? screen_height_reg
                                                          : div_quo_reg[11:0];
    assign col_inc = {1'b0, col_reg} + 13'd1;

    // Divider step
    assign div_partial = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign div_diff    = {1'b0, div_partial} - {2'b00, div_den_reg};

    // Root step
    assign sq_rem_shift = {sq_rem_reg[26:0], sq_rad_reg[SQ_W-1 -: 2]};
    assign sq_trial     = {1'b0, sq_root_reg, 2'b01};

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        line_next      = line_reg;
        idx_next       = idx_reg;
        travel_next    = travel_reg;
        oa_next        = oa_reg;
        q_next         = q_reg;
        aoc_next       = aoc_reg;
        dist_next      = dist_reg;
        z_next         = z_reg;
        sqa_next       = sqa_reg;
        drawn_next     = drawn_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        shade_next     = shade_reg;
        col_next       = col_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;
        sq_start       = 1'b0;
        sq_radicand    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && req_item.req_type)
                begin
                    px_next   = req_item.pos_x;
                    py_next   = req_item.pos_y;
                    dx_next   = req_item.dir_x;
                    dy_next   = req_item.dir_y;
                    c_next    = {(cell_size_reg != 16'd0) ? cell_size_reg : 16'd1, 8'd0};
                    d_next    = {(max_distance_reg != 16'd0) ? max_distance_reg : 16'd1,
                                 8'd0};
                    z_next    = {(max_distance_reg != 16'd0) ? max_distance_reg : 16'd1,
                                 8'd0} - 24'd256;
                    axis_next = 1'b0;
                    state_next = S_AXIS;
                end
            end
            S_AXIS:
            begin
                // Skip an axis with no motion along it
                if (da == 16'sd0)
                begin
                    if (axis_reg)
                        state_next = S_FIN;
                    else
                        axis_next = 1'b1;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(pa);
                    div_divisor  = c_reg;
                    state_next   = S_FIRST;
                end
            end
            S_FIRST:
            begin
                if (!div_busy_reg)
                begin
                    line_next   = 27'(pa) - 27'(div_rem_reg) + (da_pos ? 27'(c_reg) : 27'sd0);
                    idx_next    = 27'(div_quo_reg) + (da_pos ? 27'sd1 : 27'sd0);
                    travel_next = '0;
                    state_next  = S_STEP;
                end
            end
            S_STEP:
            begin
                if (travel_reg >= 26'(d_reg))
                begin
                    if (axis_reg)
                        state_next = S_FIN;
                    else
                    begin
                        axis_next  = 1'b1;
                        state_next = S_AXIS;
                    end
                end
                else
                begin
                    oa_next    = line_reg - 27'(pa);
                    state_next = S_MULOC;
                end
            end
            S_MULOC:
            begin
                mul_a      = oa_mag;
                mul_b      = 25'(dc_mag);
                state_next = S_DIVOC;
            end
            S_DIVOC:
            begin
                div_start    = 1'b1;
                div_dividend = prod_reg[DIV_W-1:0];
                div_divisor  = 24'(da_mag);
                state_next   = S_WOC;
            end
            S_WOC:
            begin
                if (!div_busy_reg)
                begin
                    if (div_quo_reg > DIV_W'(d_reg))
                    begin
                        if (axis_reg)
                            state_next = S_FIN;
                        else
                        begin
                            axis_next  = 1'b1;
                            state_next = S_AXIS;
                        end
                    end
                    else
                    begin
                        aoc_next = div_quo_reg[23:0];
                        // Offset across is truncated toward zero; sign from the operands
                        if (oa_reg[26] ^ dc[15] ^ da[15])
                            q_next = 27'(pc) - 27'(div_quo_reg[23:0]);
                        else
                            q_next = 27'(pc) + 27'(div_quo_reg[23:0]);
                        state_next = S_SQA;
                    end
                end
            end
            S_SQA:
            begin
                mul_a      = oa_mag;
                mul_b      = oa_mag;
                state_next = S_SQC;
            end
            S_SQC:
            begin
                sqa_next   = prod_reg;
                mul_a      = 25'(aoc_reg);
                mul_b      = 25'(aoc_reg);
                state_next = S_SQRT0;
            end
            S_SQRT0:
            begin
                sq_start    = 1'b1;
                sq_radicand = SQ_W'(sqa_reg) + SQ_W'(prod_reg);
                state_next  = S_WSQ;
            end
            S_WSQ:
            begin
                if (!sq_busy_reg)
                begin
                    if (sq_root_reg > ROOT_W'(d_reg))
                    begin
                        if (axis_reg)
                            state_next = S_FIN;
                        else
                        begin
                            axis_next  = 1'b1;
                            state_next = S_AXIS;
                        end
                    end
                    else if (line_reg < 27'sd0 || idx_reg > map_a_lim || q_reg < 27'sd0)
                        state_next = S_ADV;
                    else
                    begin
                        dist_next    = sq_root_reg[23:0];
                        div_start    = 1'b1;
                        div_dividend = DIV_W'(q_reg);
                        div_divisor  = c_reg;
                        state_next   = S_WQ;
                    end
                end
            end
            S_WQ:
            begin
                if (!div_busy_reg)
                begin
                    // Crossing point beyond the map edge: pass over it
                    if (div_quo_reg > map_c_lim ||
                        (div_quo_reg == map_c_lim && div_rem_reg != 24'd0))
                        state_next = S_ADV;
                    else
                        state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                // Map row was read at the last edge; test the cell bit
                if (wall_hit)
                begin
                    // Vertical hit always taken; horizontal only if nearer
                    if (!axis_reg || dist_reg < z_reg)
                        z_next = dist_reg;
                    if (axis_reg)
                        state_next = S_FIN;
                    else
                    begin
                        axis_next  = 1'b1;
                        state_next = S_AXIS;
                    end
                end
                else
                    state_next = S_ADV;
            end
            S_ADV:
            begin
                line_next   = da_pos ? line_reg + 27'(c_reg) : line_reg - 27'(c_reg);
                idx_next    = da_pos ? idx_reg + 27'sd1 : idx_reg - 27'sd1;
                travel_next = travel_reg + 26'(c_reg);
                state_next  = S_STEP;
            end
            S_FIN:
            begin
                drawn_next = (z_reg != 24'd0) && (z_reg < d_reg);
                start_next = '0;
                end_next   = '0;
                shade_next = '0;
                if ((z_reg != 24'd0) && (z_reg < d_reg))
                begin
                    mul_a      = 25'(persp_scale_reg);
                    mul_b      = 25'(wall_height_reg);
                    state_next = S_FLEN;
                end
                else
                    state_next = S_OUT;
            end
            S_FLEN:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({prod_reg[27:0], 8'd0});
                div_divisor  = z_reg;
                state_next   = S_WLEN;
            end
            S_WLEN:
            begin
                if (!div_busy_reg)
                begin
                    start_next = (screen_height_reg - len) >> 1;
                    end_next   = screen_height_reg - ((screen_height_reg - len) >> 1);
                    state_next = S_FSH;
                end
            end
            S_FSH:
            begin
                mul_a      = 25'(z_reg);
                mul_b      = 25'd255;
                state_next = S_FSHD;
            end
            S_FSHD:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(prod_reg[31:0]) + DIV_W'(d_reg) - DIV_W'(1);
                div_divisor  = d_reg;
                state_next   = S_WSH;
            end
            S_WSH:
            begin
                if (!div_busy_reg)
                begin
                    shade_next = 8'd255 - div_quo_reg[7:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // Hold the result until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.column    = col_reg;
                    rsp_next.distance  = z_reg;
                    rsp_next.drawn     = drawn_reg;
                    rsp_next.start_row = start_reg;
                    rsp_next.end_row   = end_reg;
                    rsp_next.shade     = shade_reg;
                    rsp_valid_next     = 1'b1;
                    col_next = (col_inc >= {1'b0, screen_width_reg}) ? 12'd0 : col_inc[11:0];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            rsp_valid_reg     <= 1'b0;
            col_reg           <= '0;
            div_busy_reg      <= 1'b0;
            sq_busy_reg       <= 1'b0;
            cell_size_reg     <= RST_CELL_SIZE;
            max_distance_reg  <= RST_MAX_DISTANCE;
            persp_scale_reg   <= RST_PERSP_SCALE;
            wall_height_reg   <= RST_WALL_HEIGHT;
            screen_height_reg <= RST_SCREEN_HEIGHT;
            screen_width_reg  <= RST_SCREEN_WIDTH;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            col_reg       <= col_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_CELL_SIZE:     cell_size_reg     <= cfg_data;
                    REG_MAX_DISTANCE:  max_distance_reg  <= cfg_data;
                    REG_PERSP_SCALE:   persp_scale_reg   <= cfg_data;
                    REG_WALL_HEIGHT:   wall_height_reg   <= cfg_data[11:0];
                    REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[11:0];
                    REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[11:0];
                    default:           ;
                endcase
            end
            // Divider control
            if (div_start)
                div_busy_reg <= 1'b1;
            else if (div_busy_reg && div_cnt_reg == 6'd1)
                div_busy_reg <= 1'b0;
            // Root control
            if (sq_start)
                sq_busy_reg <= 1'b1;
            else if (sq_busy_reg && sq_cnt_reg == 5'd1)
                sq_busy_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        axis_reg   <= axis_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        line_reg   <= line_next;
        idx_reg    <= idx_next;
        travel_reg <= travel_next;
        oa_reg     <= oa_next;
        q_reg      <= q_next;
        aoc_reg    <= aoc_next;
        dist_reg   <= dist_next;
        z_reg      <= z_next;
        sqa_reg    <= sqa_next;
        drawn_reg  <= drawn_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
        shade_reg  <= shade_next;
        rsp_reg    <= rsp_next;
        prod_reg   <= 50'(mul_a) * 50'(mul_b);
        map_word_reg <= wall_map[map_row];
        if (accept && !req_item.req_type)
            wall_map[req_item.row_index] <= req_item.row_bits;
    end

    // Restoring divider, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            div_quo_reg <= div_dividend;
            div_rem_reg <= '0;
            div_den_reg <= div_divisor;
            div_cnt_reg <= 6'(DIV_W);
        end
        else if (div_busy_reg)
        begin
            if (!div_diff[25])
            begin
                div_rem_reg <= div_diff[23:0];
                div_quo_reg <= {div_quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= div_partial[23:0];
                div_quo_reg <= {div_quo_reg[DIV_W-2:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg - 6'd1;
        end
    end

    // Digit-by-digit square root, one root bit a cycle
    always_ff @(posedge clk)
    begin
        if (sq_start)
        begin
            sq_rad_reg  <= sq_radicand;
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
            sq_cnt_reg  <= 5'(ROOT_W);
        end
        else if (sq_busy_reg)
        begin
            if (sq_rem_shift >= sq_trial)
            begin
                sq_rem_reg  <= sq_rem_shift - sq_trial;
                sq_root_reg <= {sq_root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_reg  <= sq_rem_shift;
                sq_root_reg <= {sq_root_reg[ROOT_W-2:0], 1'b0};
            end
            sq_rad_reg <= {sq_rad_reg[SQ_W-3:0], 2'b00};
            sq_cnt_reg <= sq_cnt_reg - 5'd1;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_grid_ray_cast_column.sv =====
// Self-checking testbench for grid_ray_cast_column: loads wall maps, casts rays
// under several register settings and compares every slice item with a predictor.
// Depends on grc_pkg and the grid_ray_cast_column RTL.
`default_nettype none

module tb_grid_ray_cast_column;
    import grc_pkg::*;

    localparam int MAP_W = 16;
    localparam int MAP_H = 16;
    localparam longint POS_MAX = 64'hFF_FFFF;

    // Predictor of the column slice for each ray plus the queue of slices
    // still owed by the block. Holds its own copy of the map and registers.
    class column_slice_board;
        rsp_t            owed_slices[$];
        int              errors;
        longint unsigned cell_size, max_dist, persp, wall_h, scr_h, scr_w;
        logic [15:0]     wall_rows[16];
        longint unsigned col_count;

        function new();
            cell_size = RST_CELL_SIZE;
            max_dist  = RST_MAX_DISTANCE;
            persp     = RST_PERSP_SCALE;
            wall_h    = RST_WALL_HEIGHT;
            scr_h     = RST_SCREEN_HEIGHT;
            scr_w     = RST_SCREEN_WIDTH;
            col_count = 0;
            errors    = 0;
            foreach (wall_rows[i]) wall_rows[i] = '0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                REG_CELL_SIZE:     cell_size = val;
                REG_MAX_DISTANCE:  max_dist  = val;
                REG_PERSP_SCALE:   persp     = val;
                REG_WALL_HEIGHT:   wall_h    = val[11:0];
                REG_SCREEN_HEIGHT: scr_h     = val[11:0];
                REG_SCREEN_WIDTH:  scr_w     = val[11:0];
                default: ;
            endcase
        endfunction

        // Floor square root, built one result bit at a time.
        function longint unsigned floor_root(longint unsigned v);
            longint unsigned r, t;
            r = 0;
            for (int i = 31; i >= 0; i--)
            begin
                t = r | (64'd1 << i);
                if (t * t <= v) r = t;
            end
            return r;
        endfunction

        // Cells outside the stored map count as open.
        function bit wall_at(longint row, longint col);
            if (row < 0 || col < 0 || row >= MAP_H || col >= MAP_W) return 0;
            return wall_rows[row][col];
        endfunction

        // Walk the grid lines normal to one axis; report the first wall hit.
        function bit walk_axis(longint pa, longint pc, longint da, longint dc,
                               longint lim_a, longint lim_c, bit vert,
                               longint cs, longint dl, output longint hit_dist);
            longint step, first, line, oa, oc, aoa, aoc, ray_len, q, ia, ic;
            hit_dist = 0;
            step  = (da > 0) ? cs : -cs;
            first = (pa / cs + ((da > 0) ? 1 : 0)) * cs;
            for (line = first; ((line < first) ? first - line : line - first) < dl;
                 line += step)
            begin
                oa  = line - pa;
                oc  = oa * dc / da;
                aoa = (oa < 0) ? -oa : oa;
                aoc = (oc < 0) ? -oc : oc;
                if (aoc > dl) break;
                ray_len = longint'(floor_root(aoa * aoa + aoc * aoc));
                if (ray_len > dl) break;
                q = pc + oc;
                if (line < 0 || line > lim_a || q < 0 || q > lim_c) continue;
                ia = line / cs + ((da > 0) ? 0 : -1);
                ic = q / cs;
                if (vert ? wall_at(ic, ia) : wall_at(ia, ic))
                begin
                    hit_dist = ray_len;
                    return 1;
                end
            end
            return 0;
        endfunction

        // Note an accepted request: store a map row or queue the expected slice.
        function void note_request(req_t r);
            longint cs, dl, px, py, dx, dy, z, hit, len, hh, st, sh;
            rsp_t   s;
            if (r.req_type == 1'b0)
            begin
                wall_rows[r.row_index] = r.row_bits;
                return;
            end
            cs = longint'((cell_size == 0) ? 1 : cell_size) * 256;
            dl = longint'((max_dist == 0) ? 1 : max_dist) * 256;
            px = r.pos_x;
            py = r.pos_y;
            dx = $signed(r.dir_x);
            dy = $signed(r.dir_y);
            z  = dl - 256;
            if (dx != 0 && walk_axis(px, py, dx, dy, cs * MAP_W, cs * MAP_H, 1, cs, dl, hit))
                z = hit;
            if (dy != 0 && walk_axis(py, px, dy, dx, cs * MAP_H, cs * MAP_W, 0, cs, dl, hit))
                if (hit < z) z = hit;
            s = '0;
            s.column   = col_count[11:0];
            s.distance = z[23:0];
            s.drawn    = (z > 0 && z < dl);
            if (s.drawn)
            begin
                hh  = longint'(scr_h);
                len = longint'(persp) * longint'(wall_h) * 256 / z;
                if (len > hh) len = hh;
                st = (hh - len) / 2;
                sh = 255 - (255 * z + dl - 1) / dl;
                if (sh > 255) sh = 255;
                if (sh < 0) sh = 0;
                s.start_row = st[11:0];
                s.end_row   = 12'(hh - st);
                s.shade     = sh[7:0];
            end
            owed_slices.push_back(s);
            col_count++;
            if (col_count >= scr_w) col_count = 0;
        endfunction

        task report(string what, longint got, longint want);
            $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_slice(rsp_t got);
            rsp_t want;
            if (owed_slices.size() == 0)
            begin
                report("unexpected slice item, column", got.column, -1);
                return;
            end
            want = owed_slices.pop_front();
            if (got.column    !== want.column)    report("column", got.column, want.column);
            if (got.distance  !== want.distance)  report("distance", got.distance, want.distance);
            if (got.drawn     !== want.drawn)     report("drawn", got.drawn, want.drawn);
            if (got.start_row !== want.start_row) report("start_row", got.start_row, want.start_row);
            if (got.end_row   !== want.end_row)   report("end_row", got.end_row, want.end_row);
            if (got.shade     !== want.shade)     report("shade", got.shade, want.shade);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req_item;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp_item;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    column_slice_board board;
    bit  quiet_sender;     // no gaps between items while set
    bit  quiet_receiver;   // no stalls while set
    int  hold_request;     // cycles of forced receiver hold-off, taken by the receiver

    grid_ray_cast_column #(
        .MAP_WIDTH  (MAP_W),
        .MAP_HEIGHT (MAP_H)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones.
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offer one item and hold it until the block takes it.
    task offer_request(req_t r);
        int gap;
        gap = quiet_sender ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= r;
        do @(posedge clk); while (req_stall);
        board.note_request(r);
    endtask

    task write_row(int idx, logic [15:0] bits);
        req_t r;
        r = '0;
        r.req_type  = 1'b0;
        r.row_index = idx[3:0];
        r.row_bits  = bits;
        r.pos_x     = 24'($urandom());
        r.dir_x     = 16'($urandom());
        offer_request(r);
    endtask

    task cast_ray(longint px, longint py, logic [15:0] dx, logic [15:0] dy);
        req_t r;
        r = '0;
        r.req_type  = 1'b1;
        r.row_index = 4'($urandom());
        r.row_bits  = 16'($urandom());
        r.pos_x     = px[23:0];
        r.pos_y     = py[23:0];
        r.dir_x     = dx;
        r.dir_y     = dy;
        offer_request(r);
    endtask

    // Drain the block, then write all six registers back to back.
    task load_registers(logic [15:0] cs, logic [15:0] md, logic [15:0] ps,
                        logic [15:0] wh, logic [15:0] sh, logic [15:0] sw);
        logic [15:0] vals[6];
        vals = '{cs, md, ps, wh, sh, sw};
        req_valid <= 1'b0;
        while (board.owed_slices.size() > 0) @(posedge clk);
        // let a trailing row write land first
        repeat (8) @(posedge clk);
        for (int i = 0; i < 6; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            board.set_reg(3'(i), vals[i]);
        end
        cfg_write <= 1'b0;
    endtask

    function logic [15:0] pick_dir();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 16'sd0;
        if (r < 20) return 16'h7FFF;
        if (r < 25) return 16'h8000;
        return 16'($urandom());
    endfunction

    // One random phase: mostly rays from inside the map, some map rewrites.
    task random_phase(int count);
        longint cs, span;
        int     r;
        cs   = longint'((board.cell_size == 0) ? 1 : board.cell_size) * 256;
        span = cs * MAP_W;
        if (span > POS_MAX) span = POS_MAX;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0) quiet_sender = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 22)
                write_row($urandom_range(0, 15),
                          ($urandom_range(0, 2) == 0) ? 16'($urandom() & $urandom())
                                                      : 16'($urandom()));
            else if (r < 32)
                cast_ray($urandom_range(0, 24'hFF_FFFF), $urandom_range(0, 24'hFF_FFFF),
                         pick_dir(), pick_dir());
            else
                cast_ray($urandom_range(0, int'(span)), $urandom_range(0, int'(span)),
                         pick_dir(), pick_dir());
        end
        quiet_sender = 1'b0;
    endtask

    // Receiver: check slices as they are taken, stall at random, honor hold-offs.
    initial
    begin
        int  run_left;
        bit  stall_on;
        int  hold_left;
        run_left  = 0;
        stall_on  = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall) board.check_slice(rsp_item);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    stall_on = !quiet_receiver && ($urandom_range(0, 2) == 0);
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                           : $urandom_range(1, 4);
                end
                run_left--;
                rsp_stall <= stall_on;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        longint mid;
        clk            = 1'b0;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_item       = '0;
        rsp_stall      = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
        hold_request   = 0;
        board          = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walled border with a few interior blocks; every row written before any ray.
        for (int i = 0; i < 16; i++)
            write_row(i, (i == 0 || i == 15) ? 16'hFFFF
                                             : ((i == 5) ? 16'h8F01 : 16'h8001));

        // Directed rays under reset settings: axis-aligned, zero direction,
        // extreme directions, map corners and a position off the map.
        mid = 8 * 256000 + 128000;
        cast_ray(mid, mid, 16'h4000, 16'h0000);
        cast_ray(mid, mid, 16'hC000, 16'h0000);
        cast_ray(mid, mid, 16'h0000, 16'h4000);
        cast_ray(mid, mid, 16'h0000, 16'hC000);
        cast_ray(mid, mid, 16'h0000, 16'h0000);
        cast_ray(mid, mid, 16'h7FFF, 16'h8000);
        cast_ray(mid, 300000, 16'h8000, 16'h7FFF);
        cast_ray(0, 0, 16'h2D41, 16'h2D41);
        cast_ray(POS_MAX, POS_MAX, 16'hC000, 16'hC000);
        cast_ray(4096000, 1, 16'hFFFF, 16'h0001);

        random_phase(120);

        // Sender keeps going while the receiver holds off, so the block backs up.
        hold_request = 8000;
        random_phase(30);

        load_registers(16'd1, 16'd16, 16'd65535, 16'd4095, 16'd4095, 16'd4095);
        random_phase(130);
        load_registers(16'd65535, 16'd65535, 16'd0, 16'd0, 16'd1, 16'd1);
        random_phase(100);
        // zero cell size and distance act as one
        load_registers(16'd0, 16'd0, 16'd7, 16'd100, 16'd480, 16'd640);
        random_phase(100);
        load_registers(16'd200, 16'd3000, 16'd3, 16'd2000, 16'd600, 16'd1000);
        random_phase(60);
        quiet_receiver = 1'b1;
        random_phase(60);
        quiet_receiver = 1'b0;
        // screen width below the column counter forces a wrap
        load_registers(16'd5000, 16'd1000, 16'd40, 16'd4000, 16'd1080, 16'd5);
        random_phase(100);
        load_registers(16'd37, 16'd500, 16'd1, 16'd648, 16'd1080, 16'd1920);
        random_phase(100);

        req_valid <= 1'b0;
        while (board.owed_slices.size() > 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (board.errors == 0 && board.owed_slices.size() == 0)
            $display("grid_ray_cast_column verification clean");
        else
            $display("grid_ray_cast_column verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #200000000;
        $display("grid_ray_cast_column verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/grc_pkg.sv
hw/rtl/grid_ray_cast_column.sv
tb/tb_grid_ray_cast_column.sv
